@@ rtl/bresenham_line_stepper_defines.svh @@
// assertion macros for the line stepper
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

`ifndef SYNTH
`define BLS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bls check failed");
`define BLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bls check failed");
`else
`define BLS_ASSERT_IMPLY(label, ante, cons)
`define BLS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/bls_pkg.sv @@
package bls_pkg;

    localparam logic MODE_LOAD   = 1'b0;
    localparam int   ADDR_BITS   = 20;
    localparam int   COLOUR_BITS = 32;
    localparam int   QUEUE_DEPTH = 2;

    typedef struct packed {
        logic is_load;
        logic dir_x_neg;
        logic dir_y_neg;
    } bls_ctl_t;

endpackage

@@ rtl/bls_if.sv @@
interface bls_in_if
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic        [COLOUR_BITS-1:0] colour;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, colour, input ready);
    modport sink   (input valid, mode, start_x, start_y, end_x, end_y, colour, output ready);
endinterface

interface bls_out_if
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic        [ADDR_BITS-1:0]   pixel_address;
    logic        [COLOUR_BITS-1:0] pixel_colour;
    logic                          write_enable;
    logic                          last;

    modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                    write_enable, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                    write_enable, last, output ready);
endinterface

@@ rtl/bls_front.sv @@
module bls_front
    import bls_pkg::*;
#(
    parameter  int COORD_BITS = 12,
    localparam int DATA_W     = 6 * COORD_BITS + COLOUR_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    bls_in_if.sink            cmd,
    output logic              q_valid,
    input  logic              q_ready,
    output bls_ctl_t          q_ctl,
    output logic [DATA_W-1:0] q_data
);

    logic                        valid_reg;
    logic                        valid_next;
    bls_ctl_t                    ctl_reg;
    bls_ctl_t                    ctl_next;
    logic [DATA_W-1:0]           data_reg;
    logic [DATA_W-1:0]           data_next;
    logic                        accept;
    logic signed [COORD_BITS:0]  diff_x;
    logic signed [COORD_BITS:0]  diff_y;
    logic [COORD_BITS-1:0]       abs_x;
    logic [COORD_BITS-1:0]       abs_y;

    assign cmd.ready = !valid_reg || q_ready;
    assign accept    = cmd.valid && cmd.ready;

    // endpoint setup for a load word
    always_comb
    begin
        diff_x = $signed({cmd.end_x[COORD_BITS-1], cmd.end_x})
               - $signed({cmd.start_x[COORD_BITS-1], cmd.start_x});
        diff_y = $signed({cmd.end_y[COORD_BITS-1], cmd.end_y})
               - $signed({cmd.start_y[COORD_BITS-1], cmd.start_y});
        abs_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
        abs_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);

        ctl_next.is_load   = (cmd.mode == MODE_LOAD);
        ctl_next.dir_x_neg = !(cmd.start_x < cmd.end_x);
        ctl_next.dir_y_neg = !(cmd.start_y < cmd.end_y);
        data_next = {cmd.colour, abs_y, abs_x, cmd.end_y, cmd.end_x, cmd.start_y, cmd.start_x};
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg  <= ctl_next;
            data_reg <= data_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_ctl   = ctl_reg;
    assign q_data  = data_reg;

endmodule

@@ rtl/bls_queue.sv @@
module bls_queue
    import bls_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  bls_ctl_t          push_ctl,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output bls_ctl_t          pop_ctl,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bls_ctl_t          ctl_mem  [QUEUE_DEPTH];
    logic [DATA_W-1:0] data_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_ctl    = ctl_mem[rd_ptr_reg];
    assign pop_data   = data_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg]  <= push_ctl;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/bls_back.sv @@
module bls_back
    import bls_pkg::*;
#(
    parameter  int SCREEN_W   = 1024,
    parameter  int SCREEN_H   = 768,
    parameter  int COORD_BITS = 12,
    localparam int DATA_W     = 6 * COORD_BITS + COLOUR_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  bls_ctl_t          pop_ctl,
    input  logic [DATA_W-1:0] pop_data,
    bls_out_if.source         pix
);

    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    // line state
    logic signed [C-1:0]      cur_x_reg, cur_x_next;
    logic signed [C-1:0]      cur_y_reg, cur_y_next;
    logic signed [C-1:0]      target_x_reg, target_x_next;
    logic signed [C-1:0]      target_y_reg, target_y_next;
    logic [C-1:0]             delta_x_reg, delta_x_next;
    logic [C-1:0]             delta_y_reg, delta_y_next;
    logic signed [E-1:0]      error_reg, error_next;
    logic                     dir_x_neg_reg, dir_x_neg_next;
    logic                     dir_y_neg_reg, dir_y_neg_next;
    logic [COLOUR_BITS-1:0]   colour_reg, colour_next;
    logic                     active_reg, active_next;

    // pixel stage
    logic                     a_valid_reg, a_valid_next;
    logic signed [C-1:0]      a_x_reg;
    logic signed [C-1:0]      a_y_reg;
    logic [COLOUR_BITS-1:0]   a_colour_reg;
    logic                     a_inside_reg;
    logic                     a_last_reg;

    // address stage
    logic                     b_valid_reg, b_valid_next;
    logic signed [C-1:0]      b_x_reg;
    logic signed [C-1:0]      b_y_reg;
    logic [ADDR_BITS-1:0]     b_addr_reg;
    logic [COLOUR_BITS-1:0]   b_colour_reg;
    logic                     b_inside_reg;
    logic                     b_last_reg;

    logic                     a_ready;
    logic                     b_ready;
    logic                     take;
    logic                     load;
    logic                     step;
    logic                     at_end;
    logic                     on_screen;
    logic                     mov_x;
    logic                     mov_y;
    logic signed [E-1:0]      dx_e;
    logic signed [E-1:0]      dy_e;
    logic signed [E-1:0]      e2;
    logic signed [E-1:0]      ld_dx_e;
    logic signed [E-1:0]      ld_dy_e;
    logic [ADDR_BITS-1:0]     addr;

    assign b_ready   = !b_valid_reg || pix.ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign pop_ready = a_ready;
    assign take      = pop_valid && pop_ready;
    assign load      = take && pop_ctl.is_load;
    assign step      = take && !pop_ctl.is_load && active_reg;

    assign at_end = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);
    assign on_screen = !cur_x_reg[C-1] && (int'(cur_x_reg) < SCREEN_W)
                    && !cur_y_reg[C-1] && (int'(cur_y_reg) < SCREEN_H);

    assign dx_e    = $signed({3'b000, delta_x_reg});
    assign dy_e    = $signed({3'b000, delta_y_reg});
    assign e2      = $signed({error_reg[E-2:0], 1'b0});
    assign mov_x   = e2 > -dy_e;
    assign mov_y   = e2 <= dx_e;
    assign ld_dx_e = $signed({3'b000, pop_data[5*C-1:4*C]});
    assign ld_dy_e = $signed({3'b000, pop_data[6*C-1:5*C]});

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        target_x_next  = target_x_reg;
        target_y_next  = target_y_reg;
        delta_x_next   = delta_x_reg;
        delta_y_next   = delta_y_reg;
        error_next     = error_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        colour_next    = colour_reg;
        active_next    = active_reg;

        if (load)
        begin
            cur_x_next     = $signed(pop_data[C-1:0]);
            cur_y_next     = $signed(pop_data[2*C-1:C]);
            target_x_next  = $signed(pop_data[3*C-1:2*C]);
            target_y_next  = $signed(pop_data[4*C-1:3*C]);
            delta_x_next   = pop_data[5*C-1:4*C];
            delta_y_next   = pop_data[6*C-1:5*C];
            error_next     = ld_dx_e - ld_dy_e;
            dir_x_neg_next = pop_ctl.dir_x_neg;
            dir_y_neg_next = pop_ctl.dir_y_neg;
            colour_next    = pop_data[DATA_W-1:6*C];
            active_next    = 1'b1;
        end
        else if (step)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                error_next = error_reg - (mov_x ? dy_e : E'(0)) + (mov_y ? dx_e : E'(0));
                if (mov_x)
                begin
                    cur_x_next = dir_x_neg_reg ? cur_x_reg - C'(1) : cur_x_reg + C'(1);
                end
                if (mov_y)
                begin
                    cur_y_next = dir_y_neg_reg ? cur_y_reg - C'(1) : cur_y_reg + C'(1);
                end
            end
        end
    end

    assign a_valid_next = a_ready ? step : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    // linear address, zero off screen
    assign addr = a_inside_reg
                ? ADDR_BITS'($unsigned(a_x_reg))
                  + ADDR_BITS'($unsigned(a_y_reg)) * ADDR_BITS'(SCREEN_W)
                : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            error_reg     <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            colour_reg    <= '0;
            active_reg    <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            target_x_reg  <= target_x_next;
            target_y_reg  <= target_y_next;
            delta_x_reg   <= delta_x_next;
            delta_y_reg   <= delta_y_next;
            error_reg     <= error_next;
            dir_x_neg_reg <= dir_x_neg_next;
            dir_y_neg_reg <= dir_y_neg_next;
            colour_reg    <= colour_next;
            active_reg    <= active_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            a_x_reg      <= cur_x_reg;
            a_y_reg      <= cur_y_reg;
            a_colour_reg <= colour_reg;
            a_inside_reg <= on_screen;
            a_last_reg   <= at_end;
        end
        if (b_ready && a_valid_reg)
        begin
            b_x_reg      <= a_x_reg;
            b_y_reg      <= a_y_reg;
            b_addr_reg   <= addr;
            b_colour_reg <= a_colour_reg;
            b_inside_reg <= a_inside_reg;
            b_last_reg   <= a_last_reg;
        end
    end

    assign pix.valid         = b_valid_reg;
    assign pix.pixel_x       = b_x_reg;
    assign pix.pixel_y       = b_y_reg;
    assign pix.pixel_address = b_addr_reg;
    assign pix.pixel_colour  = b_colour_reg;
    assign pix.write_enable  = b_inside_reg;
    assign pix.last          = b_last_reg;

endmodule

@@ rtl/bresenham_line_stepper.sv @@
// a step word goes through the front register, queue, pixel stage and address stage
// throughput: one word per cycle while pix.ready allows, set by the one-step error update
// a load word gives no pixel and passes through the same queue as a step word
// reset: asynchronous, active low; clears the queue, all valid flags and the line state
// after reset no line is active and words are accepted at once
`include "bresenham_line_stepper_defines.svh"

module bresenham_line_stepper
    import bls_pkg::*;
#(
    parameter int SCREEN_W   = 1024,
    parameter int SCREEN_H   = 768,
    parameter int COORD_BITS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    bls_in_if.sink    cmd,
    bls_out_if.source pix
);

    localparam int DATA_W = 6 * COORD_BITS + COLOUR_BITS;

    logic              push_valid;
    logic              push_ready;
    bls_ctl_t          push_ctl;
    logic [DATA_W-1:0] push_data;
    logic              pop_valid;
    logic              pop_ready;
    bls_ctl_t          pop_ctl;
    logic [DATA_W-1:0] pop_data;

    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (push_valid),
        .q_ready (push_ready),
        .q_ctl   (push_ctl),
        .q_data  (push_data)
    );

    bls_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctl   (push_ctl),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_ctl    (pop_ctl),
        .pop_data   (pop_data)
    );

    bls_back #(
        .SCREEN_W   (SCREEN_W),
        .SCREEN_H   (SCREEN_H),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_ctl   (pop_ctl),
        .pop_data  (pop_data),
        .pix       (pix)
    );

    `BLS_ASSERT_NEXT(a_front_capture, cmd.valid && cmd.ready, push_valid)
    `BLS_ASSERT_IMPLY(a_offscreen_addr, pix.valid && !pix.write_enable, pix.pixel_address == '0)
    `BLS_ASSERT_IMPLY(a_onscreen_sign, pix.valid && pix.write_enable, !pix.pixel_x[COORD_BITS-1] && !pix.pixel_y[COORD_BITS-1])

endmodule

@@ tb/bresenham_line_stepper_tb.sv @@
module bresenham_line_stepper_tb;
    import bls_pkg::*;

    localparam int   SCREEN_W   = 1024;
    localparam int   SCREEN_H   = 768;
    localparam int   COORD_BITS = 12;
    localparam int   LATENCY    = 3;
    localparam logic MODE_STEP  = 1'b1;
    localparam int   COORD_MAX  = 2047;
    localparam int   COORD_MIN  = -2048;

    typedef struct packed {
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [ADDR_BITS-1:0]   addr;
        logic [COLOUR_BITS-1:0] col;
        logic                   we;
        logic                   last;
    } pixel_t;

    logic clk;
    logic rst_n;

    bls_in_if  #(.COORD_BITS(COORD_BITS)) cmd_if ();
    bls_out_if #(.COORD_BITS(COORD_BITS)) pix_if ();

    bresenham_line_stepper #(
        .SCREEN_W   (SCREEN_W),
        .SCREEN_H   (SCREEN_H),
        .COORD_BITS (COORD_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .pix   (pix_if)
    );

    // line state of the predictor
    int               ln_x, ln_y, ln_tx, ln_ty;
    int               ln_dx, ln_dy, ln_err;
    bit               ln_xneg, ln_yneg, ln_active;
    logic [COLOUR_BITS-1:0] ln_col;

    pixel_t pixel_q[$];

    int send_idle_pct;
    int rcv_idle_pct;
    int hold_left;
    int words_sent;
    int useful_words;
    int lines_loaded;
    int pixels_checked;
    int mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("timeout: %0d pixels still expected", pixel_q.size());
        $display("bresenham_line_stepper_tb: errors");
        $finish;
    end

    // receiver side ready, with a counted long hold-off
    initial
    begin
        pix_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pix_if.ready <= 1'b0;
            end
            else
                pix_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    function automatic bit predict_pixel(input logic m, input logic [COORD_BITS-1:0] sx,
                                         input logic [COORD_BITS-1:0] sy,
                                         input logic [COORD_BITS-1:0] ex,
                                         input logic [COORD_BITS-1:0] ey,
                                         input logic [COLOUR_BITS-1:0] col,
                                         output pixel_t px);
        int  e2;
        bit  on_screen;
        px = '0;
        if (m == MODE_LOAD)
        begin
            ln_x      = int'($signed(sx));
            ln_y      = int'($signed(sy));
            ln_tx     = int'($signed(ex));
            ln_ty     = int'($signed(ey));
            ln_dx     = (ln_tx > ln_x) ? ln_tx - ln_x : ln_x - ln_tx;
            ln_dy     = (ln_ty > ln_y) ? ln_ty - ln_y : ln_y - ln_ty;
            ln_err    = ln_dx - ln_dy;
            ln_xneg   = !(ln_x < ln_tx);
            ln_yneg   = !(ln_y < ln_ty);
            ln_col    = col;
            ln_active = 1'b1;
            return 1'b0;
        end
        if (!ln_active)
            return 1'b0;
        on_screen = ln_x >= 0 && ln_x < SCREEN_W && ln_y >= 0 && ln_y < SCREEN_H;
        px.x    = COORD_BITS'(ln_x);
        px.y    = COORD_BITS'(ln_y);
        px.addr = on_screen ? ADDR_BITS'(ln_x + ln_y * SCREEN_W) : '0;
        px.col  = ln_col;
        px.we   = on_screen;
        px.last = (ln_x == ln_tx) && (ln_y == ln_ty);
        if (px.last)
            ln_active = 1'b0;
        else
        begin
            e2 = ln_err * 2;
            if (e2 > -ln_dy)
            begin
                ln_err -= ln_dy;
                ln_x   += ln_xneg ? -1 : 1;
            end
            if (e2 <= ln_dx)
            begin
                ln_err += ln_dx;
                ln_y   += ln_yneg ? -1 : 1;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_word(input logic m, input logic [COORD_BITS-1:0] sx,
                             input logic [COORD_BITS-1:0] sy,
                             input logic [COORD_BITS-1:0] ex,
                             input logic [COORD_BITS-1:0] ey,
                             input logic [COLOUR_BITS-1:0] col);
        pixel_t px;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_if.valid   <= 1'b1;
        cmd_if.mode    <= m;
        cmd_if.start_x <= sx;
        cmd_if.start_y <= sy;
        cmd_if.end_x   <= ex;
        cmd_if.end_y   <= ey;
        cmd_if.colour  <= col;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        words_sent++;
        if (m == MODE_LOAD)
        begin
            lines_loaded++;
            useful_words++;
        end
        if (predict_pixel(m, sx, sy, ex, ey, col, px))
        begin
            pixel_q.push_back(px);
            useful_words++;
        end
    endtask

    task automatic send_load(input int sx, input int sy, input int ex, input int ey,
                             input logic [COLOUR_BITS-1:0] col);
        send_word(MODE_LOAD, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex),
                  COORD_BITS'(ey), col);
    endtask

    // a step word carries junk in the fields it ignores
    task automatic send_step();
        send_word(MODE_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom);
    endtask

    task automatic settle_all();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    function automatic void report_mismatch(input string what, input pixel_t want,
                                            input pixel_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s: expected x=%0d y=%0d addr=%h col=%h we=%b last=%b",
                     what, $signed(want.x), $signed(want.y), want.addr, want.col, want.we,
                     want.last);
            $display("    got x=%0d y=%0d addr=%h col=%h we=%b last=%b",
                     $signed(got.x), $signed(got.y), got.addr, got.col, got.we, got.last);
        end
    endfunction

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && pix_if.valid && pix_if.ready)
        begin
            got = {pix_if.pixel_x, pix_if.pixel_y, pix_if.pixel_address, pix_if.pixel_colour,
                   pix_if.write_enable, pix_if.last};
            if (pixel_q.size() == 0)
                report_mismatch("unexpected pixel", '0, got);
            else
            begin
                want = pixel_q.pop_front();
                pixels_checked++;
                if (got !== want)
                    report_mismatch("pixel mismatch", want, got);
            end
        end
    end

    function automatic int pick_coord(input int lim);
        if ($urandom_range(0, 1))
            return int'($urandom_range(0, 16)) - 8;
        return lim - 8 + int'($urandom_range(0, 16));
    endfunction

    task automatic test_idle_step();
        send_step();
    endtask

    task automatic test_extreme_lines();
        send_load(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
        repeat (3) send_step();
        // reload while the previous line is still active
        send_load(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32'h0000_0000);
        repeat (2) send_step();
    endtask

    task automatic test_special_lines();
        send_load(0, 0, 0, 0, 32'hA5A5_5A5A);
        send_step();
        send_load(SCREEN_W - 4, 5, SCREEN_W + 2, 5, 32'h1234_5678);
        repeat (7) send_step();
        send_load(3, SCREEN_H - 3, 3, SCREEN_H + 1, 32'h8765_4321);
        repeat (5) send_step();
        send_step();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        @(negedge clk);
        hold_left = 300;
        send_load(0, 0, 40, 17, 32'hCAFE_F00D);
        repeat (41) send_step();
        settle_all();
    endtask

    task automatic test_random_lines(input int target);
        int goal;
        int sx, sy, ex, ey, span, nsteps, r, rs;
        goal = useful_words + target;
        while (useful_words < goal)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                sx = pick_coord(SCREEN_W);
                sy = pick_coord(SCREEN_H);
            end
            else
            begin
                sx = int'($signed(COORD_BITS'($urandom)));
                sy = int'($signed(COORD_BITS'($urandom)));
            end
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                ex = int'($signed(COORD_BITS'($urandom)));
                ey = int'($signed(COORD_BITS'($urandom)));
            end
            else
            begin
                span = (r < 90) ? 12 : (r < 99) ? 60 : 300;
                ex = sx + int'($urandom_range(0, 2 * span)) - span;
                ey = sy + int'($urandom_range(0, 2 * span)) - span;
                ex = (ex > COORD_MAX) ? COORD_MAX : (ex < COORD_MIN) ? COORD_MIN : ex;
                ey = (ey > COORD_MAX) ? COORD_MAX : (ey < COORD_MIN) ? COORD_MIN : ey;
            end
            send_load(sx, sy, ex, ey, $urandom);
            nsteps = (ex > sx) ? ex - sx : sx - ex;
            if (((ey > sy) ? ey - sy : sy - ey) > nsteps)
                nsteps = (ey > sy) ? ey - sy : sy - ey;
            nsteps++;
            rs = $urandom_range(0, 99);
            if (r < 5)
                nsteps = $urandom_range(0, 10);
            else if (rs < 10)
                nsteps = $urandom_range(0, nsteps - 1);
            else if (rs < 20)
                nsteps += $urandom_range(1, 3);
            repeat (nsteps) send_step();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.mode    = MODE_LOAD;
        cmd_if.start_x = '0;
        cmd_if.start_y = '0;
        cmd_if.end_x   = '0;
        cmd_if.end_y   = '0;
        cmd_if.colour  = '0;
        send_idle_pct  = 22;
        rcv_idle_pct   = 75;
        hold_left      = 0;
        words_sent     = 0;
        useful_words   = 0;
        lines_loaded   = 0;
        pixels_checked = 0;
        mismatches     = 0;
        ln_x = 0; ln_y = 0; ln_tx = 0; ln_ty = 0;
        ln_dx = 0; ln_dy = 0; ln_err = 0;
        ln_xneg = 0; ln_yneg = 0; ln_active = 0; ln_col = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_step();
        test_extreme_lines();
        test_special_lines();
        settle_all();

        send_idle_pct = 22;
        rcv_idle_pct  = 75;
        test_random_lines(430);
        settle_all();

        send_idle_pct = 75;
        rcv_idle_pct  = 22;
        test_random_lines(430);
        settle_all();

        test_backpressure();

        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        test_random_lines(430);
        settle_all();

        mismatches += pixel_q.size();
        $display("sent %0d words (%0d lines), checked %0d pixels, %0d mismatches",
                 words_sent, lines_loaded, pixels_checked, mismatches);
        $display("extreme, degenerate, clipped and random lines; three idle mixes; long stall");
        if (mismatches == 0)
            $display("bresenham_line_stepper_tb: clean");
        else
            $display("bresenham_line_stepper_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bls_pkg.sv
rtl/bls_if.sv
rtl/bls_front.sv
rtl/bls_queue.sv
rtl/bls_back.sv
rtl/bresenham_line_stepper.sv
tb/bresenham_line_stepper_tb.sv
